### src/h264fua_pkg.sv
package h264fua_pkg;

	localparam logic [7:0]  RTP_V2       = 8'h80;
	localparam logic [4:0]  FU_A_TYPE    = 5'd28;
	localparam logic [38:0] TICKS_PER_MS = 39'd90;
	localparam logic [38:0] TS_WRAP      = 39'h00FFFFFFFF;
	localparam logic [15:0] MIN_PACKET   = 16'd228;
	localparam logic [15:0] HEADER_BYTES = 16'd14;
	localparam logic [31:0] SSRC_VALUE   = 32'd10;
	localparam logic [10:0] PSIZE_RESET  = 11'd1400;
	localparam logic [6:0]  PTYPE_RESET  = 7'd96;
	localparam logic        REG_PSIZE    = 1'b0;
	localparam logic        REG_PTYPE    = 1'b1;

	typedef enum logic [1:0] {
		JOB_BYTE,
		JOB_SINGLE,
		JOB_FRAG
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        marker;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic [7:0]  data;
		logic        last;
	} job_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] origin;
	} stream_st_t;

endpackage

### src/h264fua_mem.sv
module h264fua_mem #(
	parameter int STREAMS = 8,
	parameter int AW = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output h264fua_pkg::stream_st_t rd_data,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  h264fua_pkg::stream_st_t wr_data
);
	import h264fua_pkg::*;

	stream_st_t          mem [STREAMS];
	logic [STREAMS-1:0]  vld_q;
	stream_st_t          rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr] || (wr_en && wr_addr == rd_addr);
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// entries never written read as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### src/h264fua_ctrl.sv
module h264fua_ctrl #(
	parameter int STREAMS = 8,
	parameter int AW = 3,
	parameter int FW = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              in_sidx,
	input  logic [7:0]              in_byte,
	input  logic                    in_start,
	input  logic [15:0]             in_len,
	input  logic [31:0]             in_now,
	input  logic [15:0]             limit,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  h264fua_pkg::stream_st_t rd_data,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output h264fua_pkg::stream_st_t wr_data,
	output h264fua_pkg::job_t       job,
	output logic                    job_valid,
	input  logic                    job_take
);
	import h264fua_pkg::*;

	logic        valid_s1;
	logic [2:0]  sidx_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [15:0] len_s1;
	logic [31:0] now_s1;

	logic [2:0]    cur_q, cur_n;
	logic [15:0]   left_q, left_n;
	logic [FW-1:0] fill_q, fill_n;
	logic [7:0]    hdr_q, hdr_n;
	logic [31:0]   ts_q, ts_n;
	logic          frag_q, frag_n;
	logic          first_q, first_n;

	logic          need;
	logic          go;
	logic [31:0]   org, tick;
	logic [38:0]   prod;
	logic [15:0]   left_m1;
	logic          last_frag;
	logic [FW-1:0] fill_m1;

	always_comb begin
		org     = (rd_data.origin == '0 || now_s1 < rd_data.origin) ? now_s1 : rd_data.origin;
		tick    = now_s1 - org;
		prod    = {7'd0, tick} * TICKS_PER_MS;
		left_m1 = left_q - 16'd1;
		last_frag = left_q <= limit;

		cur_n   = cur_q;
		left_n  = left_q;
		fill_n  = fill_q;
		hdr_n   = hdr_q;
		ts_n    = ts_q;
		frag_n  = frag_q;
		first_n = first_q;
		fill_m1 = '0;
		need    = 1'b0;
		wr_en   = 1'b0;
		wr_addr = AW'(cur_q);
		wr_data = rd_data;
		job     = '0;
		job.kind = JOB_BYTE;
		job.data = byte_s1;
		job.ts   = ts_q;
		job.seq  = rd_data.seq;

		if (valid_s1) begin
			if (start_s1) begin
				left_n  = '0;
				fill_n  = '0;
				frag_n  = 1'b0;
				first_n = 1'b0;
				if (32'(sidx_s1) < STREAMS) begin
					cur_n   = sidx_s1;
					hdr_n   = byte_s1;
					ts_n    = prod[31:0];
					left_n  = (len_s1 == '0) ? 16'd0 : len_s1 - 16'd1;
					wr_en   = 1'b1;
					wr_addr = AW'(sidx_s1);
					wr_data.origin = (prod >= TS_WRAP) ? 32'd0 : org;
					if (left_n <= limit) begin
						need = 1'b1;
						wr_data.seq = rd_data.seq + 16'd1;
						job.kind   = JOB_SINGLE;
						job.marker = 1'b1;
						job.ts     = prod[31:0];
						job.last   = left_n == '0;
					end else begin
						frag_n  = 1'b1;
						first_n = 1'b1;
					end
				end
			end else if (left_q != '0) begin
				need   = 1'b1;
				left_n = left_m1;
				if (!frag_q) begin
					job.last = left_m1 == '0;
				end else begin
					fill_m1 = fill_q - FW'(1);
					if (fill_q == '0) begin
						// packet boundary: new RTP + FU header
						fill_m1 = (last_frag ? FW'(left_q) : FW'(limit)) - FW'(1);
						wr_en   = 1'b1;
						wr_data.seq = rd_data.seq + 16'd1;
						job.kind   = JOB_FRAG;
						job.marker = last_frag;
						job.fu_ind = {hdr_q[7:5], FU_A_TYPE};
						job.fu_hdr = {first_q, last_frag, 1'b0, hdr_q[4:0]};
						first_n    = 1'b0;
					end
					fill_n   = fill_m1;
					job.last = fill_m1 == '0;
					frag_n   = left_m1 != '0;
				end
			end
		end
	end

	assign go        = valid_s1 && (!need || job_take);
	assign job_valid = valid_s1 && need;
	assign in_ready  = !valid_s1 || go;
	assign rd_en     = in_valid && in_ready;
	assign rd_addr   = in_start ? AW'(in_sidx) : AW'(cur_n);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sidx_s1  <= in_sidx;
			byte_s1  <= in_byte;
			start_s1 <= in_start;
			len_s1   <= in_len;
			now_s1   <= in_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cur_q    <= '0;
			left_q   <= '0;
			fill_q   <= '0;
			hdr_q    <= '0;
			ts_q     <= '0;
			frag_q   <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				cur_q   <= cur_n;
				left_q  <= left_n;
				fill_q  <= fill_n;
				hdr_q   <= hdr_n;
				ts_q    <= ts_n;
				frag_q  <= frag_n;
				first_q <= first_n;
			end
		end
	end

endmodule

### src/h264fua_emit.sv
module h264fua_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  h264fua_pkg::job_t job,
	input  logic              job_valid,
	output logic              job_take,
	input  logic [6:0]        ptype,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_first,
	output logic              out_last
);
	import h264fua_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic [3:0] end_idx;
	logic       done;

	always_comb begin
		case (job_q.kind)
			JOB_SINGLE: end_idx = 4'd12;
			JOB_FRAG:   end_idx = 4'd14;
			default:    end_idx = 4'd0;
		endcase
		out_byte = job_q.data;
		if (job_q.kind != JOB_BYTE) begin
			case (idx_q)
				4'd0:    out_byte = RTP_V2;
				4'd1:    out_byte = {job_q.marker, ptype};
				4'd2:    out_byte = job_q.seq[15:8];
				4'd3:    out_byte = job_q.seq[7:0];
				4'd4:    out_byte = job_q.ts[31:24];
				4'd5:    out_byte = job_q.ts[23:16];
				4'd6:    out_byte = job_q.ts[15:8];
				4'd7:    out_byte = job_q.ts[7:0];
				4'd8:    out_byte = SSRC_VALUE[31:24];
				4'd9:    out_byte = SSRC_VALUE[23:16];
				4'd10:   out_byte = SSRC_VALUE[15:8];
				4'd11:   out_byte = SSRC_VALUE[7:0];
				4'd12:   out_byte = (job_q.kind == JOB_FRAG) ? job_q.fu_ind : job_q.data;
				4'd13:   out_byte = job_q.fu_hdr;
				default: out_byte = job_q.data;
			endcase
		end
	end

	assign out_valid = busy_q;
	assign out_first = job_q.kind != JOB_BYTE && idx_q == '0;
	assign out_last  = idx_q == end_idx && job_q.last;
	assign done      = busy_q && out_ready && idx_q == end_idx;
	assign job_take  = !busy_q || done;

	always_ff @(posedge clk) begin
		if (job_valid && job_take) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (job_valid && job_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

### src/h264_rtp_fua_packetizer_unit.sv
// H.264 RTP packetizer with FU-A fragmentation for up to STREAMS streams. NAL bytes enter
// one per transfer; the first byte of a NAL carries nal_start, its length and the time in ms.
// Per-stream sequence counter and timestamp origin live in a small state RAM, read as a byte
// is taken and written back as it is processed. Payload bytes flow at one per cycle while
// m_tready holds; a byte that opens a packet occupies the output sequencer while it sends
// the 12-byte RTP header and the byte (single NAL packet), or also FU indicator and FU header
// (FU-A fragment), during which the input stalls once the one-item pipeline stage is full.
// The output is a byte stream; tuser marks the first, tlast the last byte of each RTP packet.
module h264_rtp_fua_packetizer_unit #(
	parameter int STREAMS = 8,
	parameter int MAX_PACKET = 1500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // nal_byte[7:0], nal_length[23:8], now_ms[55:24]
	input  logic [3:0]  s_tuser,  // stream_index[2:0], nal_start[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // packet_byte[7:0]
	output logic        m_tuser,  // packet_first[0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import h264fua_pkg::*;

	localparam int AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int FW = $clog2(MAX_PACKET);
	localparam logic [15:0] MAX_P = 16'(MAX_PACKET);

	logic [10:0] psize_q;
	logic [6:0]  ptype_q;
	logic [15:0] psize_c;
	logic [15:0] limit;

	logic          rd_en, wr_en, job_valid, job_take;
	logic [AW-1:0] rd_addr, wr_addr;
	stream_st_t    rd_data, wr_data;
	job_t          job;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PTYPE) ? {25'd0, ptype_q} : {21'd0, psize_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= PSIZE_RESET;
			ptype_q <= PTYPE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_PSIZE: psize_q <= pwdata[10:0];
				REG_PTYPE: ptype_q <= pwdata[6:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		psize_c = {5'd0, psize_q};
		if (psize_c < MIN_PACKET) psize_c = MIN_PACKET;
		if (psize_c > MAX_P) psize_c = MAX_P;
		limit = psize_c - HEADER_BYTES;
	end

	h264fua_mem #(.STREAMS(STREAMS), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	h264fua_ctrl #(.STREAMS(STREAMS), .AW(AW), .FW(FW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sidx   (s_tuser[2:0]),
		.in_byte   (s_tdata[7:0]),
		.in_start  (s_tuser[3]),
		.in_len    (s_tdata[23:8]),
		.in_now    (s_tdata[55:24]),
		.limit     (limit),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job       (job),
		.job_valid (job_valid),
		.job_take  (job_take)
	);

	h264fua_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.job_take  (job_take),
		.ptype     (ptype_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_first (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
